// File: hdl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// shared types, codes and constants of the heartbeat monitor
// ----------------------------------------------------------------------------
package chm_pkg;

  // node table geometry
  localparam int unsigned NODE_COUNT = 127;
  localparam int unsigned NODE_W     = 7;
  localparam int unsigned MEM_DEPTH  = 2 ** NODE_W;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned STATE_W    = 7;
  localparam int unsigned MEM_W      = STATE_W + TIME_BITS;

  // field widths
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned FRAME_ID_W = 11;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned FRAMES_W   = 32;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned MASK_W     = 2 * CFG_DATA_W;

  // identifier ranges
  localparam logic [FRAME_ID_W-1:0] HB_BASE  = 11'h700;
  localparam logic [FRAME_ID_W-1:0] HB_LAST  = FRAME_ID_W'(HB_BASE + NODE_COUNT);
  localparam logic [FRAME_ID_W-1:0] SDO_BASE = 11'h580;
  localparam logic [FRAME_ID_W-1:0] SDO_LAST = 11'h67F;
  localparam logic [FRAME_ID_W-1:0] PDO_BASE = 11'h180;
  localparam logic [FRAME_ID_W-1:0] PDO_LAST = 11'h57F;
  localparam logic [FRAME_ID_W-1:0] NMT_ID   = 11'h000;
  localparam logic [LEN_W-1:0]      HB_LEN   = 4'd1;

  // node state codes
  localparam logic [STATE_W-1:0] NS_BOOT    = 7'd0;
  localparam logic [STATE_W-1:0] NS_STOPPED = 7'd4;
  localparam logic [STATE_W-1:0] NS_OPER    = 7'd5;
  localparam logic [STATE_W-1:0] NS_PREOP   = 7'd127;

  // configuration reset values
  localparam logic [THR_W-1:0]  FLASH_RST   = 16'd1000;
  localparam logic [THR_W-1:0]  SHOW_RST    = 16'd30000;
  localparam logic [THR_W-1:0]  FAIL_RST    = 16'd2000;
  localparam logic [MASK_W-1:0] PRESENT_RST = '1;

  localparam logic [NODE_W-1:0] NODE_FIRST = NODE_W'(1);
  localparam logic [NODE_W-1:0] NODE_LAST  = NODE_W'(NODE_COUNT);

  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME   = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_QUERY   = 3'd2,
    CMD_SUMMARY = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOOT_FLASH   = 3'd0,
    CFG_BOOT_SHOW    = 3'd1,
    CFG_FAILURE      = 3'd2,
    CFG_PRESENT_LOW  = 3'd3,
    CFG_PRESENT_HIGH = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CLS_FRESH_BOOT = 3'd0,
    CLS_BOOT       = 3'd1,
    CLS_STOPPED    = 3'd2,
    CLS_OPER       = 3'd3,
    CLS_PREOP      = 3'd4,
    CLS_INVALID    = 3'd5,
    CLS_DOWN       = 3'd6,
    CLS_DOWN_UNEXP = 3'd7
  } class_e;

  localparam logic KIND_QUERY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [FRAME_ID_W-1:0] frame_id;
    logic [LEN_W-1:0]      frame_length;
    logic [BYTE_W-1:0]     first_byte;
    logic [NODE_W-1:0]     query_node;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [2:0]          node_class;
    logic [CNT_W-1:0]    operational_count;
    logic [CNT_W-1:0]    preop_count;
    logic [CNT_W-1:0]    stopped_count;
    logic [CNT_W-1:0]    boot_count;
    logic [CNT_W-1:0]    failure_count;
    logic [FRAMES_W-1:0] total_frames;
    logic [FRAMES_W-1:0] mgmt_frames;
    logic [FRAMES_W-1:0] service_frames;
    logic [FRAMES_W-1:0] process_frames;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAME,
    ST_TICK,
    ST_CLEAR,
    ST_Q_READ,
    ST_Q_AGE,
    ST_Q_CLASS,
    ST_S_READ,
    ST_S_AGE,
    ST_S_CLASS,
    ST_S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic do_frame;
    logic do_tick;
    logic do_clear;
    logic rd_issue;
    logic age_calc;
    logic class_acc;
    logic node_next;
    logic out_query;
    logic out_summary;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic last_node;
  } ctrl_stat_t;

endpackage

// File: hdl/chm_ctrl.sv
// ----------------------------------------------------------------------------
// chm_ctrl
// sequencer: decodes accepted items and steps the datapath through them
// ----------------------------------------------------------------------------
module chm_ctrl import chm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [CMD_W-1:0]     in_cmd_i,
  output logic                 in_ready_o,
  input  ctrl_stat_t           stat_i,
  output ctrl_cmd_t            cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          priority case (in_cmd_i)
            CMD_FRAME:   state_d = ST_FRAME;
            CMD_TICK:    state_d = ST_TICK;
            CMD_QUERY:   state_d = ST_Q_READ;
            CMD_SUMMARY: state_d = ST_S_READ;
            CMD_CLEAR:   state_d = ST_CLEAR;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_FRAME: begin
        cmd_o.do_frame = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_TICK: begin
        cmd_o.do_tick = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd_o.do_clear = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_Q_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_Q_AGE;
      end
      ST_Q_AGE: begin
        cmd_o.age_calc = 1'b1;
        state_d        = ST_Q_CLASS;
      end
      ST_Q_CLASS: begin
        // hold the classified node until the output register is free
        if (stat_i.out_free) begin
          cmd_o.out_query = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_S_AGE;
      end
      ST_S_AGE: begin
        cmd_o.age_calc = 1'b1;
        state_d        = ST_S_CLASS;
      end
      ST_S_CLASS: begin
        cmd_o.class_acc = 1'b1;
        if (stat_i.last_node) begin
          state_d = ST_S_DONE;
        end else begin
          cmd_o.node_next = 1'b1;
          state_d         = ST_S_READ;
        end
      end
      ST_S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_summary = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/chm_dp.sv
// ----------------------------------------------------------------------------
// chm_dp
// datapath: config registers, node table, frame counters, classifier, output
// ----------------------------------------------------------------------------
module chm_dp import chm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  in_item_t              in_item_i,
  input  ctrl_cmd_t             cmd_i,
  output ctrl_stat_t            stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  // configuration
  logic [THR_W-1:0]  flash_q, show_q, fail_q;
  logic [MASK_W-1:0] present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_q   <= FLASH_RST;
      show_q    <= SHOW_RST;
      fail_q    <= FAIL_RST;
      present_q <= PRESENT_RST;
    end else if (cfg_we_i) begin
      priority case (cfg_index_i)
        CFG_BOOT_FLASH:   flash_q <= cfg_wdata_i[THR_W-1:0];
        CFG_BOOT_SHOW:    show_q  <= cfg_wdata_i[THR_W-1:0];
        CFG_FAILURE:      fail_q  <= cfg_wdata_i[THR_W-1:0];
        CFG_PRESENT_LOW:  present_q[CFG_DATA_W-1:0] <= cfg_wdata_i;
        CFG_PRESENT_HIGH: present_q[MASK_W-1:CFG_DATA_W] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // accepted item and node pointer
  in_item_t          item_q;
  logic [NODE_W-1:0] ptr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
      ptr_q  <= (in_item_i.cmd == CMD_QUERY) ? in_item_i.query_node : NODE_FIRST;
    end else if (cmd_i.node_next) begin
      ptr_q <= ptr_q + NODE_W'(1);
    end
  end

  // frame decode
  logic is_hb, is_nmt, is_sdo, is_pdo;
  logic [NODE_W-1:0] hb_node;

  assign is_hb  = (item_q.frame_id > HB_BASE) && (item_q.frame_id <= HB_LAST) &&
                  (item_q.frame_length == HB_LEN);
  assign is_nmt = (item_q.frame_id == NMT_ID);
  assign is_sdo = (item_q.frame_id > SDO_BASE) && (item_q.frame_id <= SDO_LAST);
  assign is_pdo = (item_q.frame_id > PDO_BASE) && (item_q.frame_id <= PDO_LAST);
  assign hb_node = NODE_W'(item_q.frame_id - HB_BASE);

  // time and frame counters
  logic [TIME_BITS-1:0] now_q;
  logic [FRAMES_W-1:0]  total_q, mgmt_q, service_q, process_q;
  logic [MEM_DEPTH-1:0] seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q     <= '0;
      total_q   <= '0;
      mgmt_q    <= '0;
      service_q <= '0;
      process_q <= '0;
      seen_q    <= '0;
    end else begin
      if (cmd_i.do_tick) begin
        now_q <= now_q + TIME_BITS'(1);
      end
      if (cmd_i.do_clear) begin
        total_q   <= '0;
        mgmt_q    <= '0;
        service_q <= '0;
        process_q <= '0;
        seen_q    <= '0;
      end else if (cmd_i.do_frame) begin
        total_q <= total_q + FRAMES_W'(1);
        if (is_hb || is_nmt) begin
          mgmt_q <= mgmt_q + FRAMES_W'(1);
        end
        if (is_sdo) begin
          service_q <= service_q + FRAMES_W'(1);
        end
        if (is_pdo) begin
          process_q <= process_q + FRAMES_W'(1);
        end
        if (is_hb) begin
          seen_q[hb_node] <= 1'b1;
        end
      end
    end
  end

  // node table: state and heartbeat time per node
  logic [MEM_W-1:0] mem_q [MEM_DEPTH];
  logic [MEM_W-1:0] rd_q;
  logic             rd_seen_q, rd_present_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_frame && is_hb) begin
      mem_q[hb_node] <= {item_q.first_byte[STATE_W-1:0], now_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_q         <= mem_q[ptr_q];
      rd_seen_q    <= seen_q[ptr_q];
      rd_present_q <= present_q[ptr_q];
    end
  end

  // age stage
  logic [TIME_BITS-1:0] age_q;
  logic [STATE_W-1:0]   st_q;
  logic                 seen_a_q, present_a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.age_calc) begin
      age_q       <= now_q - rd_q[TIME_BITS-1:0];
      st_q        <= rd_q[MEM_W-1:TIME_BITS];
      seen_a_q    <= rd_seen_q;
      present_a_q <= rd_present_q;
    end
  end

  // classifier
  class_e cls;
  class_e cls_down;

  assign cls_down = present_a_q ? CLS_DOWN : CLS_DOWN_UNEXP;

  always_comb begin
    cls = cls_down;
    if (seen_a_q) begin
      if ((st_q == NS_BOOT) && (age_q < TIME_BITS'(flash_q))) begin
        cls = CLS_FRESH_BOOT;
      end else if ((st_q == NS_BOOT) && (age_q < TIME_BITS'(show_q))) begin
        cls = CLS_BOOT;
      end else if (age_q < TIME_BITS'(fail_q)) begin
        priority case (st_q)
          NS_STOPPED: cls = CLS_STOPPED;
          NS_OPER:    cls = CLS_OPER;
          NS_PREOP:   cls = CLS_PREOP;
          default:    cls = CLS_INVALID;
        endcase
      end
    end
  end

  // summary tallies
  logic [CNT_W-1:0] op_cnt_q, preop_cnt_q, stop_cnt_q, boot_cnt_q, fail_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_cnt_q    <= '0;
      preop_cnt_q <= '0;
      stop_cnt_q  <= '0;
      boot_cnt_q  <= '0;
      fail_cnt_q  <= '0;
    end else if (cmd_i.class_acc) begin
      unique case (cls)
        CLS_FRESH_BOOT, CLS_BOOT: boot_cnt_q  <= boot_cnt_q + CNT_W'(1);
        CLS_STOPPED:              stop_cnt_q  <= stop_cnt_q + CNT_W'(1);
        CLS_OPER:                 op_cnt_q    <= op_cnt_q + CNT_W'(1);
        CLS_PREOP:                preop_cnt_q <= preop_cnt_q + CNT_W'(1);
        CLS_INVALID, CLS_DOWN:    fail_cnt_q  <= fail_cnt_q + CNT_W'(1);
        CLS_DOWN_UNEXP: ;
      endcase
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t query_item, sum_item;

  always_comb begin
    query_item            = '0;
    query_item.kind       = KIND_QUERY;
    query_item.node_class = cls;

    sum_item                   = '0;
    sum_item.kind              = KIND_SUMMARY;
    sum_item.operational_count = op_cnt_q;
    sum_item.preop_count       = preop_cnt_q;
    sum_item.stopped_count     = stop_cnt_q;
    sum_item.boot_count        = boot_cnt_q;
    sum_item.failure_count     = fail_cnt_q;
    sum_item.total_frames      = total_q;
    sum_item.mgmt_frames       = mgmt_q;
    sum_item.service_frames    = service_q;
    sum_item.process_frames    = process_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_query || cmd_i.out_summary) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_query) begin
      out_item_q <= query_item;
    end else if (cmd_i.out_summary) begin
      out_item_q <= sum_item;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_item_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.last_node = (ptr_q == NODE_LAST);

endmodule

// File: hdl/can_heartbeat_monitor_unit.sv
// ----------------------------------------------------------------------------
// can_heartbeat_monitor_unit
// heartbeat consumer: tracks node states from bus frames, answers node
// queries and produces table summaries with frame statistics
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                payload
// -------  ---------  -----------------------  ---------------------------
// in       input      in_valid_i / in_ready_o  in_item_i  (in_item_t)
// out      output     out_valid_o/out_ready_i  out_item_o (out_item_t)
// cfg      input      cfg_we_i, no wait        cfg_index_i, cfg_wdata_i
//
// one item at a time: frame, tick and clear each pass through their own
// state and then return to ready; a query steps through table read, age
// subtract and classify; a summary walks nodes 1 to 127 through the same
// read / age / classify steps, node by node on the single table read port
// results sit in an output register, so frames and ticks keep flowing
// while a result waits; a new query or summary stalls only at its end if
// the previous result has not been transferred yet
// reset clears seen bits, time and counters at once; the node table itself
// is not cleared since the entry of an unseen node is never used
//
module can_heartbeat_monitor_unit import chm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // item input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  // command and status between sequencer and datapath
  ctrl_cmd_t  ctrl_cmd;
  ctrl_stat_t ctrl_stat;

  // sequencer: owns the input handshake
  chm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_item_i.cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (ctrl_stat),
    .cmd_o      (ctrl_cmd)
  );

  // datapath: table, counters, classifier and output register
  chm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (ctrl_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hdl/chm_checker.sv
// ----------------------------------------------------------------------------
// chm_checker
// port level checks on the result channel of the heartbeat monitor
// ----------------------------------------------------------------------------
module chm_checker import chm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a pending result holds until transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed or dropped while stalled");

  // query answers carry no tallies or frame counters
  a_query_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_QUERY) |->
      (out_item_o.operational_count == '0) && (out_item_o.preop_count == '0) &&
      (out_item_o.stopped_count == '0) && (out_item_o.boot_count == '0) &&
      (out_item_o.failure_count == '0) && (out_item_o.total_frames == '0) &&
      (out_item_o.mgmt_frames == '0) && (out_item_o.service_frames == '0) &&
      (out_item_o.process_frames == '0))
    else $error("query answer with nonzero summary fields");

  // summaries leave the class field at zero
  a_sum_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_SUMMARY) |-> (out_item_o.node_class == '0))
    else $error("summary with nonzero node class");

  // the summary tallies together never exceed the node count
  a_sum_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_SUMMARY) |->
      ((10'(out_item_o.operational_count) + 10'(out_item_o.preop_count) +
        10'(out_item_o.stopped_count) + 10'(out_item_o.boot_count) +
        10'(out_item_o.failure_count)) <= 10'(NODE_COUNT)))
    else $error("summary tallies exceed node count");

endmodule

bind can_heartbeat_monitor_unit chm_checker u_chm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
